// ===== rtl/mcodp_pkg.sv =====
// Shared types and constants of the matrix chain order block.
// Holds the item structs, the status codes and the controller command bundle.
// No dependencies.
`timescale 1ns / 1ps

package mcodp_pkg;

	// default sizing of the block
	localparam int MAX_MATRICES_DEF = 8;
	localparam int DIM_BITS_DEF     = 10;

	// fixed field widths of the channel items
	localparam int DIMENSION_W = 10;
	localparam int INDEX_W     = 4;
	localparam int COST_W      = 33;
	localparam int SPLIT_W     = 3;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TOO_MANY = 2'd1,
		STAT_TOO_FEW  = 2'd2
	} status_t;

	// one dimension transfer
	typedef struct packed {
		logic [DIMENSION_W-1:0] dimension;
		logic                   last;
	} dim_item_t;

	// one result transfer
	typedef struct packed {
		logic [INDEX_W-1:0] chain_start;
		logic [INDEX_W-1:0] chain_end;
		logic [COST_W-1:0]  min_cost;
		logic [SPLIT_W-1:0] best_split;
		status_t            status;
		logic               final_res;
	} res_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic    dim_we;      // store the incoming dimension
		logic    setup;       // fetch outer dimensions of the subchain
		logic    issue;       // start one split candidate
		logic    first_k;     // candidate is the first split of the subchain
		logic    last_k;      // candidate is the last split of the subchain
		logic    emit;        // load the result register
		logic    emit_chain;  // result is a subchain, not a fixed result
		logic    final_res;   // result closes the run
		status_t status;      // status of a fixed result
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic done;      // subchain minimum resolved this cycle
		logic out_free;  // result register can take a new result
	} dp_stat_t;

endpackage

// ===== rtl/mcodp_dpath.sv =====
// Datapath of the matrix chain order block: dimension and cost memories,
// three-stage split-cost pipeline, running minimum and result register.
// Depends on mcodp_pkg.
`timescale 1ns / 1ps

module mcodp_dpath #(
	parameter int  MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
	parameter int  DIM_BITS     = mcodp_pkg::DIM_BITS_DEF,
	localparam int IW           = $clog2(MAX_MATRICES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcodp_pkg::dp_cmd_t  cmd,
	output mcodp_pkg::dp_stat_t stat,
	input  logic [IW-1:0]       i_idx,
	input  logic [IW-1:0]       j_idx,
	input  logic [IW-1:0]       k_idx,
	input  logic [IW-1:0]       dim_waddr,
	input  logic [DIM_BITS-1:0] dim_wdata,
	input  logic                res_stall,
	output logic                res_valid,
	output mcodp_pkg::res_item_t res_item
);
	import mcodp_pkg::*;

	localparam int AW = $clog2(MAX_MATRICES * MAX_MATRICES);
	localparam int P1W = 2 * DIM_BITS;
	localparam int PW = 3 * DIM_BITS;
	localparam int CW = 3 * DIM_BITS + $clog2(MAX_MATRICES);

	// cost table cell address, row and column from zero
	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
		input logic [IW-1:0] col);
		return AW'(row) * AW'(MAX_MATRICES) + AW'(col);
	endfunction

	logic [DIM_BITS-1:0] dim_mem [MAX_MATRICES + 1];
	logic [CW-1:0]       cost_mem [MAX_MATRICES * MAX_MATRICES];

	logic [IW-1:0]       i_m1, j_m1, k_m1, addr_a;
	logic [AW-1:0]       addr_l, addr_r, addr_w;

	logic [DIM_BITS-1:0] rda_s1, rdb_s1;
	logic [CW-1:0]       cl_s1, cr_s1;
	logic                v_s1, ends_s1, zl_s1, zr_s1, first_s1, last_s1;
	logic [IW-1:0]       k_s1;

	logic [DIM_BITS-1:0] pa_q, pb_q;

	logic [P1W-1:0]      prod1_s2;
	logic [CW-1:0]       csum_s2;
	logic                v_s2, first_s2, last_s2;
	logic [IW-1:0]       k_s2;

	logic [PW-1:0]       prod2_s3;
	logic [CW-1:0]       csum_s3;
	logic                v_s3, first_s3, last_s3;
	logic [IW-1:0]       k_s3;

	logic [CW-1:0]       cand, best_d, best_q;
	logic [IW-1:0]       bestk_d, bestk_q;
	logic                take, cost_we;

	logic                res_valid_q, out_free;
	res_item_t           res_d, res_q;

	// memory addresses
	assign i_m1   = i_idx - IW'(1);
	assign j_m1   = j_idx - IW'(1);
	assign k_m1   = k_idx - IW'(1);
	assign addr_a = cmd.setup ? i_m1 : k_idx;
	assign addr_l = cell_addr(i_m1, k_m1);
	assign addr_r = cell_addr(k_idx, j_m1);
	assign addr_w = cell_addr(i_m1, j_m1);

	// dimension and cost memories, registered reads
	always_ff @(posedge clk) begin
		if (cmd.dim_we) begin
			dim_mem[dim_waddr] <= dim_wdata;
		end
		if (cost_we) begin
			cost_mem[addr_w] <= best_d;
		end
		rda_s1 <= dim_mem[addr_a];
		rdb_s1 <= dim_mem[j_idx];
		cl_s1  <= cost_mem[addr_l];
		cr_s1  <= cost_mem[addr_r];
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ends_s1 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			ends_s1 <= cmd.setup;
		end
	end

	// stage 1: outer dimensions, first multiplication and sum of the two sub-costs
	always_ff @(posedge clk) begin
		zl_s1    <= (k_idx == i_idx);
		zr_s1    <= (k_idx + IW'(1) == j_idx);
		first_s1 <= cmd.first_k;
		last_s1  <= cmd.last_k;
		k_s1     <= k_idx;
		if (ends_s1) begin
			pa_q <= rda_s1;
			pb_q <= rdb_s1;
		end
		prod1_s2 <= P1W'(pa_q) * P1W'(rda_s1);
		csum_s2  <= (zl_s1 ? '0 : cl_s1) + (zr_s1 ? '0 : cr_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		k_s2     <= k_s1;
	end

	// stage 2: second multiplication
	always_ff @(posedge clk) begin
		prod2_s3 <= PW'(prod1_s2) * PW'(pb_q);
		csum_s3  <= csum_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		k_s3     <= k_s2;
	end

	// stage 3: candidate cost against running minimum, first k wins ties
	assign cand    = csum_s3 + CW'(prod2_s3);
	assign take    = first_s3 || (cand < best_q);
	assign best_d  = take ? cand : best_q;
	assign bestk_d = take ? k_s3 : bestk_q;
	assign cost_we = v_s3 && last_s3;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			best_q  <= best_d;
			bestk_q <= bestk_d;
		end
	end

	// next result
	always_comb begin
		res_d.final_res = cmd.final_res;
		if (cmd.emit_chain) begin
			res_d.chain_start = INDEX_W'(i_idx);
			res_d.chain_end   = INDEX_W'(j_idx);
			res_d.min_cost    = COST_W'(best_q);
			res_d.best_split  = SPLIT_W'(bestk_q);
			res_d.status      = STAT_OK;
		end else begin
			res_d.chain_start = (cmd.status == STAT_OK) ? INDEX_W'(1) : '0;
			res_d.chain_end   = (cmd.status == STAT_OK) ? INDEX_W'(1) : '0;
			res_d.min_cost    = '0;
			res_d.best_split  = '0;
			res_d.status      = cmd.status;
		end
	end

	// result register
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign res_item      = res_q;
	assign stat.done     = cost_we;
	assign stat.out_free = out_free;

endmodule

// ===== rtl/mcodp_ctrl.sv =====
// Controller of the matrix chain order block: load counting, error checks
// and the subchain / split sequencing of the dynamic program.
// Depends on mcodp_pkg.
`timescale 1ns / 1ps

module mcodp_ctrl #(
	parameter int  MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
	localparam int IW           = $clog2(MAX_MATRICES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                dim_valid,
	input  logic                last,
	output logic                dim_stall,
	output mcodp_pkg::dp_cmd_t  cmd,
	input  mcodp_pkg::dp_stat_t stat,
	output logic [IW-1:0]       i_idx,
	output logic [IW-1:0]       j_idx,
	output logic [IW-1:0]       k_idx,
	output logic [IW-1:0]       dim_waddr
);
	import mcodp_pkg::*;

	localparam int CNTW = $clog2(MAX_MATRICES + 2);

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_FIXED = 6'b000010,
		S_SETUP = 6'b000100,
		S_ISSUE = 6'b001000,
		S_DRAIN = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q, cnt_inc;
	logic            ovf_q, ovf_inc, room, accept;
	status_t         stat_q;
	logic [IW-1:0]   n_q, len_q, i_q, k_q, j_w;
	logic            k_last, j_last;

	// load bookkeeping
	assign accept  = dim_valid && (state_q == S_LOAD);
	assign room    = cnt_q < CNTW'(MAX_MATRICES + 1);
	assign cnt_inc = room ? cnt_q + CNTW'(1) : cnt_q;
	assign ovf_inc = ovf_q | ~room;

	// subchain end and loop limits
	assign j_w    = i_q + len_q - IW'(1);
	assign k_last = (k_q == j_w - IW'(1));
	assign j_last = (j_w == n_q);

	// commands
	always_comb begin
		cmd            = '0;
		cmd.dim_we     = accept && room;
		cmd.status     = stat_q;
		unique case (state_q)
			S_LOAD: begin
			end
			S_FIXED: begin
				cmd.emit      = stat.out_free;
				cmd.final_res = 1'b1;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
			end
			S_ISSUE: begin
				cmd.issue   = 1'b1;
				cmd.first_k = (k_q == i_q);
				cmd.last_k  = k_last;
			end
			S_DRAIN: begin
			end
			S_EMIT: begin
				cmd.emit       = stat.out_free;
				cmd.emit_chain = 1'b1;
				cmd.final_res  = (len_q == n_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			stat_q  <= STAT_OK;
			n_q     <= '0;
			len_q   <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (last) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (ovf_inc) begin
								stat_q  <= STAT_TOO_MANY;
								state_q <= S_FIXED;
							end else if (cnt_inc < CNTW'(2)) begin
								stat_q  <= STAT_TOO_FEW;
								state_q <= S_FIXED;
							end else if (cnt_inc == CNTW'(2)) begin
								stat_q  <= STAT_OK;
								state_q <= S_FIXED;
							end else begin
								stat_q  <= STAT_OK;
								n_q     <= IW'(cnt_inc - CNTW'(1));
								len_q   <= IW'(2);
								i_q     <= IW'(1);
								state_q <= S_SETUP;
							end
						end else begin
							cnt_q <= cnt_inc;
							ovf_q <= ovf_inc;
						end
					end
				end
				S_FIXED: begin
					if (stat.out_free) begin
						state_q <= S_LOAD;
					end
				end
				S_SETUP: begin
					k_q     <= i_q;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					k_q <= k_q + IW'(1);
					if (k_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (j_last) begin
							if (len_q == n_q) begin
								state_q <= S_LOAD;
							end else begin
								len_q   <= len_q + IW'(1);
								i_q     <= IW'(1);
								state_q <= S_SETUP;
							end
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_SETUP;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign dim_stall = (state_q != S_LOAD);
	assign i_idx     = i_q;
	assign j_idx     = j_w;
	assign k_idx     = k_q;
	assign dim_waddr = cnt_q[IW-1:0];

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_MATRICES + 1))
		else $error("dimension count beyond store depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> (cnt_q == '0) && !ovf_q)
		else $error("load state not cleared after last dimension");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded while result register is held");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == S_DRAIN))
		else $error("subchain resolved outside drain");

endmodule

// ===== rtl/matrix_chain_order_dp.sv =====
// Matrix chain multiplication order, bottom-up dynamic program.
// Depends on mcodp_pkg, mcodp_ctrl and mcodp_dpath.
// Dimension channel (dim_valid / dim_stall / dim_item): one dimension per
// transfer, last marks the final one; a chain of n matrices takes n+1
// transfers, one per cycle. dim_stall is high from last to the final result.
// Result channel (res_valid / res_stall / res_item): one result per subchain of
// two or more matrices, by length and then start, final_res on the last one;
// a single fixed result for a lone matrix or a count error.
// Solve sequence: for each subchain, while the receiver keeps up, the
// controller fetches the outer dimensions, issues one split per cycle, lets
// the three stages of the cost pipeline drain and loads the result register;
// the next subchain starts only after that. The cost memory has two read
// ports and one write port. A chain of 8 matrices takes 9 dimension transfers.
// Reset: clears the dimension count, the error flag and the result valid;
// memories are not cleared; each value the solve uses is written first.
// Receiver stall: the result register holds its transfer and the controller
// waits before loading the next result; no result is lost.
`timescale 1ns / 1ps

module matrix_chain_order_dp #(
	parameter int MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
	parameter int DIM_BITS     = mcodp_pkg::DIM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dim_valid,
	output logic                 dim_stall,
	input  mcodp_pkg::dim_item_t dim_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output mcodp_pkg::res_item_t res_item
);
	import mcodp_pkg::*;

	localparam int IW = $clog2(MAX_MATRICES + 1);

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic [IW-1:0]       i_idx, j_idx, k_idx, dim_waddr;
	logic [DIM_BITS-1:0] dim_wdata;

	// keep the low dimension bits
	assign dim_wdata = DIM_BITS'(dim_item.dimension);

	// controller
	mcodp_ctrl #(
		.MAX_MATRICES (MAX_MATRICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim_valid (dim_valid),
		.last      (dim_item.last),
		.dim_stall (dim_stall),
		.cmd       (cmd),
		.stat      (stat),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.k_idx     (k_idx),
		.dim_waddr (dim_waddr)
	);

	// datapath
	mcodp_dpath #(
		.MAX_MATRICES (MAX_MATRICES),
		.DIM_BITS     (DIM_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.k_idx     (k_idx),
		.dim_waddr (dim_waddr),
		.dim_wdata (dim_wdata),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

endmodule
